// ===== src/lrpa_pkg.sv =====
// shared types and constants for the leased resource pool allocator
package lrpa_pkg;

   localparam int MAX_UNITS = 8;
   localparam int GEN_BITS = 16;
   localparam int IDX_BITS = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
   localparam int CNT_BITS = $clog2(MAX_UNITS + 1);
   localparam int OP_BITS = 3;
   localparam int OWNER_BITS = 22;
   localparam int CFG_BITS = 4;
   localparam int STAT_BITS = 2;
   localparam int UIDX_BITS = 3;
   localparam int LGEN_BITS = 16;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      OP_ACQUIRE = 3'd0,
      OP_SET_OWNER = 3'd1,
      OP_CLEAR_OWNER = 3'd2,
      OP_CHECK = 3'd3,
      OP_CANCEL = 3'd4,
      OP_RELEASE = 3'd5,
      OP_REAP = 3'd6,
      OP_UNUSED = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_BACKGROUND = 2'd1,
      KIND_FOREGROUND = 2'd2,
      KIND_STOPPING = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_REFUSED = 2'd1,
      ST_QUARANTINED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      EXEC_IDLE,
      EXEC_SCAN_FREE,
      EXEC_SCAN_BG,
      EXEC_SCAN_CANCEL,
      EXEC_EMIT
   } exec_state_type;

   typedef struct packed {
      logic [OP_BITS-1:0] opcode;
      logic purpose;
      logic [UIDX_BITS-1:0] unit_index;
      logic [LGEN_BITS-1:0] lease_gen;
      logic [OWNER_BITS-1:0] owner_id;
      logic stop_ok;
   } req_type;

   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic [UIDX_BITS-1:0] result_index;
      logic [LGEN_BITS-1:0] result_gen;
      logic preempted;
      logic last;
   } rsp_type;

   typedef struct packed {
      op_type op;
      kind_type kind;
      logic in_pool;
      logic [IDX_BITS-1:0] unit;
      logic [UIDX_BITS-1:0] unit_index;
      logic [GEN_BITS-1:0] lease_gen;
      logic [OWNER_BITS-1:0] owner_id;
      logic stop_ok;
   } cmd_type;

   function automatic logic [GEN_BITS-1:0] gen_next(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS-1:0] n;
      n = g + 1'b1;
      if (n == '0) begin
         n = {{(GEN_BITS-1){1'b0}}, 1'b1};
      end
      return n;
   endfunction

   function automatic logic [LGEN_BITS-1:0] gen_out(input logic [GEN_BITS-1:0] g);
      logic [GEN_BITS+LGEN_BITS-1:0] w;
      w = {{LGEN_BITS{1'b0}}, g};
      return w[LGEN_BITS-1:0];
   endfunction

   function automatic logic [UIDX_BITS-1:0] idx_out(input logic [IDX_BITS-1:0] i);
      logic [IDX_BITS+UIDX_BITS-1:0] w;
      w = {{UIDX_BITS{1'b0}}, i};
      return w[UIDX_BITS-1:0];
   endfunction

endpackage

// ===== src/lrpa_stream_if.sv =====
// valid/ready channel carrying one payload
interface lrpa_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== src/leased_resource_pool_allocator.sv =====
// top level of the leased resource pool allocator
//
// channel  direction  transfer
// req      in         one request: opcode, purpose, unit_index, lease_gen, owner_id, stop_ok
// rsp      out        one result: status, result_index, result_gen, preempted, last
// csr      in         unit_count write, clears the pool
//
// simple ops are done from idle; acquire walks the units one per cycle, free scan then
// background scan; cancel walks them from unit 0, stalling while rsp is not accepted
// a two-entry command queue lets requests land while the back end works
// reset is synchronous and empties the pool with unit_count 0
module leased_resource_pool_allocator (
   input  logic clock,
   input  logic reset,
   lrpa_stream_if.sink req,
   lrpa_stream_if.source rsp,
   input  logic csr_write,
   input  logic [lrpa_pkg::CFG_BITS-1:0] csr_wdata
);
   import lrpa_pkg::*;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CFG_BITS+CNT_BITS-1:0] wd_wide;
   logic cmd_valid, cmd_pop;
   cmd_type cmd;

   always_comb begin
      wd_wide = {{CNT_BITS{1'b0}}, csr_wdata};
      if (wd_wide > (CFG_BITS+CNT_BITS)'(MAX_UNITS)) begin
         count_in = CNT_BITS'(MAX_UNITS);
      end else begin
         count_in = wd_wide[CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write) begin
         count_ff <= count_in;
      end
   end

   lrpa_front u_front (
      .clock(clock),
      .reset(reset),
      .unit_count(count_ff),
      .req(req),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop)
   );

   lrpa_back u_back (
      .clock(clock),
      .reset(reset),
      .csr_write(csr_write),
      .unit_count(count_ff),
      .cmd_valid(cmd_valid),
      .cmd(cmd),
      .cmd_pop(cmd_pop),
      .rsp(rsp)
   );

endmodule

// ===== src/lrpa_front.sv =====
// front end: request decode and command queue
module lrpa_front (
   input  logic clock,
   input  logic reset,
   input  logic [lrpa_pkg::CNT_BITS-1:0] unit_count,
   lrpa_stream_if.sink req,
   output logic cmd_valid,
   output lrpa_pkg::cmd_type cmd,
   input  logic cmd_pop
);
   import lrpa_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   cmd_type queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0] fill_ff, fill_in;
   cmd_type decoded;
   logic push;
   logic [CNT_BITS+UIDX_BITS-1:0] ui_wide, cnt_wide;

   always_comb begin
      ui_wide = {{CNT_BITS{1'b0}}, req.payload.unit_index};
      cnt_wide = {{UIDX_BITS{1'b0}}, unit_count};
      decoded.op = op_type'(req.payload.opcode);
      decoded.kind = req.payload.purpose ? KIND_FOREGROUND : KIND_BACKGROUND;
      decoded.in_pool = ui_wide < cnt_wide;
      decoded.unit = ui_wide[IDX_BITS-1:0];
      decoded.unit_index = req.payload.unit_index;
      decoded.lease_gen = GEN_BITS'(req.payload.lease_gen);
      decoded.owner_id = req.payload.owner_id;
      decoded.stop_ok = req.payload.stop_ok;
   end

   assign req.ready = fill_ff != (PTR_BITS+1)'(QUEUE_DEPTH);
   assign push = req.valid && req.ready;
   assign cmd_valid = fill_ff != '0;
   assign cmd = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== src/lrpa_back.sv =====
// back end: unit table, scan sequencer and result register
module lrpa_back (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [lrpa_pkg::CNT_BITS-1:0] unit_count,
   input  logic cmd_valid,
   input  lrpa_pkg::cmd_type cmd,
   output logic cmd_pop,
   lrpa_stream_if.source rsp
);
   import lrpa_pkg::*;

   logic busy_ff [MAX_UNITS];
   logic busy_in [MAX_UNITS];
   kind_type kind_ff [MAX_UNITS];
   kind_type kind_in [MAX_UNITS];
   logic [GEN_BITS-1:0] gen_ff [MAX_UNITS];
   logic [GEN_BITS-1:0] gen_in [MAX_UNITS];
   logic [OWNER_BITS-1:0] owner_ff [MAX_UNITS];
   logic [OWNER_BITS-1:0] owner_in [MAX_UNITS];
   logic [IDX_BITS-1:0] next_ff, next_in;
   exec_state_type state_ff, state_in;
   logic [IDX_BITS-1:0] pos_ff, pos_in;
   logic [CNT_BITS-1:0] step_ff, step_in;
   rsp_type out_ff, out_in;
   logic out_valid_ff, out_valid_in;

   logic [IDX_BITS-1:0] u, pos_wrap, last_idx;
   logic current, can_emit, later_match;
   logic [GEN_BITS-1:0] g1, g2;
   logic [CNT_BITS-1:0] steps_left;

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
   assign can_emit = !out_valid_ff || rsp.ready;
   assign u = cmd.unit;
   assign current = cmd.in_pool && busy_ff[u] && gen_ff[u] == cmd.lease_gen;
   assign last_idx = IDX_BITS'(unit_count - 1'b1);
   assign pos_wrap = (pos_ff == last_idx) ? '0 : pos_ff + 1'b1;
   assign steps_left = step_ff - 1'b1;

   // a cancel marks last on the match with no later match in the pool
   always_comb begin
      later_match = 1'b0;
      for (int i = 0; i < MAX_UNITS; i++) begin
         if (IDX_BITS'(i) > pos_ff && CNT_BITS'(i) < unit_count && busy_ff[i]
             && kind_ff[i] == cmd.kind && owner_ff[i] != '0) begin
            later_match = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      step_in = step_ff;
      next_in = next_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      cmd_pop = 1'b0;
      g1 = '0;
      g2 = '0;
      for (int i = 0; i < MAX_UNITS; i++) begin
         busy_in[i] = busy_ff[i];
         kind_in[i] = kind_ff[i];
         gen_in[i] = gen_ff[i];
         owner_in[i] = owner_ff[i];
      end
      case (state_ff)
         EXEC_IDLE: begin
            if (cmd_valid && can_emit) begin
               out_in = '{ST_REFUSED, cmd.unit_index, '0, 1'b0, 1'b1};
               out_valid_in = 1'b1;
               pos_in = next_ff;
               step_in = unit_count;
               case (cmd.op)
                  OP_ACQUIRE, OP_CANCEL: begin
                     out_valid_in = out_valid_ff && !rsp.ready;
                     if (cmd.op == OP_CANCEL) begin
                        pos_in = '0;
                     end
                     if (unit_count == '0) begin
                        out_in.result_index = '0;
                        out_valid_in = 1'b1;
                        cmd_pop = 1'b1;
                     end else if (cmd.op == OP_CANCEL) begin
                        state_in = EXEC_SCAN_CANCEL;
                     end else begin
                        state_in = EXEC_SCAN_FREE;
                     end
                  end
                  OP_SET_OWNER: begin
                     cmd_pop = 1'b1;
                     if (current && cmd.owner_id != '0) begin
                        owner_in[u] = cmd.owner_id;
                        out_in.status = ST_OK;
                        out_in.result_gen = gen_out(gen_ff[u]);
                     end
                  end
                  OP_CLEAR_OWNER: begin
                     cmd_pop = 1'b1;
                     if (current && (cmd.owner_id == '0 || owner_ff[u] == cmd.owner_id)) begin
                        owner_in[u] = '0;
                        out_in.status = ST_OK;
                        out_in.result_gen = gen_out(gen_ff[u]);
                     end
                  end
                  OP_CHECK: begin
                     cmd_pop = 1'b1;
                     if (current) begin
                        out_in.status = ST_OK;
                        out_in.result_gen = gen_out(gen_ff[u]);
                     end
                  end
                  OP_RELEASE: begin
                     cmd_pop = 1'b1;
                     if (current) begin
                        g1 = gen_next(gen_ff[u]);
                        g2 = gen_next(g1);
                        if (owner_ff[u] == '0 || cmd.stop_ok) begin
                           busy_in[u] = 1'b0;
                           kind_in[u] = KIND_NONE;
                           owner_in[u] = '0;
                           gen_in[u] = g2;
                           out_in.status = ST_OK;
                           out_in.result_gen = gen_out(g2);
                        end else begin
                           kind_in[u] = KIND_STOPPING;
                           gen_in[u] = g1;
                           out_in.status = ST_QUARANTINED;
                           out_in.result_gen = gen_out(g1);
                        end
                     end
                  end
                  OP_REAP: begin
                     cmd_pop = 1'b1;
                     if (cmd.in_pool && gen_ff[u] == cmd.lease_gen
                         && kind_ff[u] == KIND_STOPPING) begin
                        g1 = gen_next(gen_ff[u]);
                        busy_in[u] = 1'b0;
                        kind_in[u] = KIND_NONE;
                        owner_in[u] = '0;
                        gen_in[u] = g1;
                        out_in.status = ST_OK;
                        out_in.result_gen = gen_out(g1);
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                     out_in.result_index = '0;
                  end
               endcase
            end
         end
         EXEC_SCAN_FREE: begin
            if (!busy_ff[pos_ff]) begin
               g1 = gen_next(gen_ff[pos_ff]);
               busy_in[pos_ff] = 1'b1;
               kind_in[pos_ff] = cmd.kind;
               gen_in[pos_ff] = g1;
               next_in = pos_wrap;
               out_in = '{ST_OK, idx_out(pos_ff), gen_out(g1), 1'b0, 1'b1};
               state_in = EXEC_EMIT;
            end else if (steps_left == '0) begin
               pos_in = next_ff;
               step_in = unit_count;
               if (cmd.kind == KIND_FOREGROUND) begin
                  state_in = EXEC_SCAN_BG;
               end else begin
                  out_in = '{ST_REFUSED, '0, '0, 1'b0, 1'b1};
                  state_in = EXEC_EMIT;
               end
            end else begin
               pos_in = pos_wrap;
               step_in = steps_left;
            end
         end
         EXEC_SCAN_BG: begin
            if (kind_ff[pos_ff] == KIND_BACKGROUND) begin
               g1 = gen_next(gen_ff[pos_ff]);
               g2 = gen_next(g1);
               if (owner_ff[pos_ff] != '0 && !cmd.stop_ok) begin
                  kind_in[pos_ff] = KIND_STOPPING;
                  gen_in[pos_ff] = g1;
                  out_in = '{ST_QUARANTINED, idx_out(pos_ff), gen_out(g1), 1'b0, 1'b1};
               end else begin
                  kind_in[pos_ff] = KIND_FOREGROUND;
                  owner_in[pos_ff] = '0;
                  gen_in[pos_ff] = g2;
                  next_in = pos_wrap;
                  out_in = '{ST_OK, idx_out(pos_ff), gen_out(g2), 1'b1, 1'b1};
               end
               state_in = EXEC_EMIT;
            end else if (steps_left == '0) begin
               out_in = '{ST_REFUSED, '0, '0, 1'b0, 1'b1};
               state_in = EXEC_EMIT;
            end else begin
               pos_in = pos_wrap;
               step_in = steps_left;
            end
         end
         EXEC_SCAN_CANCEL: begin
            if (can_emit) begin
               if (busy_ff[pos_ff] && kind_ff[pos_ff] == cmd.kind && owner_ff[pos_ff] != '0) begin
                  g1 = gen_next(gen_ff[pos_ff]);
                  g2 = gen_next(g1);
                  out_valid_in = 1'b1;
                  if (cmd.stop_ok) begin
                     busy_in[pos_ff] = 1'b0;
                     kind_in[pos_ff] = KIND_NONE;
                     owner_in[pos_ff] = '0;
                     gen_in[pos_ff] = g2;
                     out_in = '{ST_OK, idx_out(pos_ff), gen_out(g2), 1'b0, !later_match};
                  end else begin
                     kind_in[pos_ff] = KIND_STOPPING;
                     gen_in[pos_ff] = g1;
                     out_in = '{ST_QUARANTINED, idx_out(pos_ff), gen_out(g1), 1'b0,
                                !later_match};
                  end
                  if (!later_match) begin
                     cmd_pop = 1'b1;
                     state_in = EXEC_IDLE;
                  end
               end else if (steps_left == '0) begin
                  out_in = '{ST_REFUSED, '0, '0, 1'b0, 1'b1};
                  out_valid_in = 1'b1;
                  cmd_pop = 1'b1;
                  state_in = EXEC_IDLE;
               end
               pos_in = pos_wrap;
               step_in = steps_left;
            end
         end
         EXEC_EMIT: begin
            if (can_emit) begin
               out_valid_in = 1'b1;
               cmd_pop = 1'b1;
               state_in = EXEC_IDLE;
            end
         end
         default: begin
            state_in = EXEC_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EXEC_IDLE;
         out_valid_ff <= 1'b0;
         next_ff <= '0;
         for (int i = 0; i < MAX_UNITS; i++) begin
            busy_ff[i] <= 1'b0;
            kind_ff[i] <= KIND_NONE;
            gen_ff[i] <= '0;
            owner_ff[i] <= '0;
         end
      end else if (csr_write) begin
         next_ff <= '0;
         for (int i = 0; i < MAX_UNITS; i++) begin
            busy_ff[i] <= 1'b0;
            kind_ff[i] <= KIND_NONE;
            gen_ff[i] <= '0;
            owner_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         next_ff <= next_in;
         for (int i = 0; i < MAX_UNITS; i++) begin
            busy_ff[i] <= busy_in[i];
            kind_ff[i] <= kind_in[i];
            gen_ff[i] <= gen_in[i];
            owner_ff[i] <= owner_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      step_ff <= step_in;
      out_ff <= out_in;
   end

endmodule
